// ===== rtl/scancode_set1_key_translator_core_assert.svh =====
// Assertion macros for the scancode translator checker in rtl/sckt_checker.sv.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef SCANCODE_SET1_KEY_TRANSLATOR_CORE_ASSERT_SVH
`define SCANCODE_SET1_KEY_TRANSLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define SCKT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCKT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sckt_pkg.sv =====
// Types, scancode constants and keymap tables for the set-1 key translator.
// No dependencies.
package sckt_pkg;

    localparam int TERMINAL_COUNT_DEF = 3;

    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [7:0] SC_WIN_L  = 8'h5B;
    localparam logic [7:0] SC_WIN_R  = 8'h5C;
    localparam logic [6:0] SC_ALT    = 7'h38;
    localparam logic [6:0] SC_CTRL   = 7'h1D;
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CAPS   = 7'h3A;
    localparam logic [6:0] SC_F1     = 7'h3B;
    localparam logic [6:0] SC_F10    = 7'h44;
    localparam logic [6:0] SC_F11    = 7'h57;
    localparam logic [7:0] FKEY_BASE = 8'hB0;

    localparam logic [7:0] SC_UP     = 8'h48;
    localparam logic [7:0] SC_DOWN   = 8'h50;
    localparam logic [7:0] SC_LEFT   = 8'h4B;
    localparam logic [7:0] SC_RIGHT  = 8'h4D;
    localparam logic [7:0] SC_DEL    = 8'h53;
    localparam logic [7:0] SC_HOME   = 8'h47;
    localparam logic [7:0] SC_END    = 8'h4F;

    localparam logic [3:0] ACT_KEY      = 4'd0;
    localparam logic [3:0] ACT_TERMINAL = 4'd1;
    localparam logic [3:0] ACT_MENU     = 4'd2;
    localparam logic [3:0] ACT_FILES    = 4'd3;
    localparam logic [3:0] ACT_MAXIMIZE = 4'd9;

    typedef struct packed {
        logic prefix;
        logic shift;
        logic alt;
        logic ctrl;
        logic caps;
    } key_state_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] action;
        logic [7:0] key_code;
        logic [1:0] terminal_index;
    } key_result_t;

    localparam logic [7:0] MAP_PLAIN [64] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] MAP_SHIFTED [64] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

// ===== rtl/sckt_decode.sv =====
// Combinational scancode decode: next modifier state and the optional result.
// Depends on sckt_pkg.
module sckt_decode #(
    parameter int TERMINAL_COUNT = sckt_pkg::TERMINAL_COUNT_DEF
) (
    input  logic [7:0]          scancode,
    input  sckt_pkg::key_state_t  st,
    output sckt_pkg::key_state_t  st_next,
    output sckt_pkg::key_result_t res
);
    import sckt_pkg::*;

    localparam logic [6:0] F_TERM_END = 7'(SC_F1 + TERMINAL_COUNT);
    localparam logic [6:0] F_APP_LAST = 7'(SC_F1 + TERMINAL_COUNT + 5);

    logic       rel;
    logic [6:0] code;
    logic [6:0] fk_off;
    logic [6:0] app_off;
    logic [7:0] map_c;
    logic [7:0] caps_c;
    logic [7:0] chr;
    logic [7:0] ext_c;
    logic       is_letter;

    assign rel     = scancode[7];
    assign code    = scancode[6:0];
    assign fk_off  = code - SC_F1;
    assign app_off = code - F_TERM_END;

    always_comb
    begin
        map_c  = st.shift ? MAP_SHIFTED[code[5:0]] : MAP_PLAIN[code[5:0]];
        caps_c = map_c;
        if (st.caps && (map_c inside {[8'h61:8'h7A], [8'h41:8'h5A]}))
        begin
            caps_c = map_c ^ 8'h20;
        end
        is_letter = caps_c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
        chr = (st.ctrl && is_letter) ? {3'b000, caps_c[4:0]} : caps_c;
    end

    always_comb
    begin
        case (scancode)
            SC_UP:    ext_c = st.shift ? 8'h90 : 8'h80;
            SC_DOWN:  ext_c = st.shift ? 8'h91 : 8'h81;
            SC_LEFT:  ext_c = st.shift ? 8'h92 : 8'h82;
            SC_RIGHT: ext_c = st.shift ? 8'h93 : 8'h83;
            SC_DEL:   ext_c = 8'h84;
            SC_HOME:  ext_c = st.shift ? 8'h94 : 8'h85;
            SC_END:   ext_c = st.shift ? 8'h95 : 8'h86;
            default:  ext_c = 8'h00;
        endcase
    end

    always_comb
    begin
        st_next = st;
        res     = '0;
        if (scancode == SC_PREFIX)
        begin
            st_next.prefix = 1'b1;
        end
        else if (st.prefix)
        begin
            st_next.prefix = 1'b0;
            if (!rel)
            begin
                if (scancode == SC_WIN_L || scancode == SC_WIN_R)
                begin
                    res.valid  = 1'b1;
                    res.action = ACT_MENU;
                end
                else if (ext_c != 8'h00)
                begin
                    res.valid    = 1'b1;
                    res.action   = ACT_KEY;
                    res.key_code = ext_c;
                end
            end
        end
        else if (code == SC_ALT)
        begin
            st_next.alt = !rel;
        end
        else if (code == SC_CTRL)
        begin
            st_next.ctrl = !rel;
        end
        else if (code inside {SC_LSHIFT, SC_RSHIFT})
        begin
            st_next.shift = !rel;
        end
        else if (code == SC_CAPS)
        begin
            if (!rel)
            begin
                st_next.caps = !st.caps;
            end
        end
        else if (st.alt && !rel && code >= SC_F1 && code < F_TERM_END)
        begin
            res.valid          = 1'b1;
            res.action         = ACT_TERMINAL;
            res.terminal_index = fk_off[1:0];
        end
        else if (st.alt && !rel && code >= F_TERM_END && code <= F_APP_LAST)
        begin
            res.valid  = 1'b1;
            res.action = ACT_FILES + app_off[3:0];
        end
        else if (!rel && code == SC_F11)
        begin
            res.valid  = 1'b1;
            res.action = ACT_MAXIMIZE;
        end
        else if (!rel && !st.alt && code >= SC_F1 && code <= SC_F10)
        begin
            res.valid    = 1'b1;
            res.action   = ACT_KEY;
            res.key_code = FKEY_BASE + {1'b0, fk_off};
        end
        else if (!rel && !code[6] && chr != 8'h00)
        begin
            res.valid    = 1'b1;
            res.action   = ACT_KEY;
            res.key_code = chr;
        end
    end

endmodule

// ===== rtl/scancode_set1_key_translator_core.sv =====
// Top level of the PS/2 set-1 scancode translator: input register, decode, result register.
// Depends on sckt_pkg and sckt_decode.
//
//  channel  dir  tdata bits                                    notes
//  s_axis   in   [7:0] scancode                                one byte per request
//  m_axis   out  [3:0] action [11:4] key_code [13:12] term_idx [15:14] zero
//
// One request per cycle unless a result stalls on m_tready; m_tdata is registered.
// The input register advances when the result register is empty, is being taken,
// or the byte yields no result; modifier state updates on that advance.
// rst_n clears valid flags and modifier state; payload registers are not reset.
module scancode_set1_key_translator_core #(
    parameter int TERMINAL_COUNT = sckt_pkg::TERMINAL_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [3:0] action, [11:4] key_code, [13:12] terminal_index
);
    import sckt_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  sc_reg;
    key_state_t  st_reg;
    key_state_t  st_next;
    key_result_t res;
    logic        out_valid_reg;
    logic [13:0] out_data_reg;
    logic        advance;

    sckt_decode #(
        .TERMINAL_COUNT(TERMINAL_COUNT)
    ) u_decode (
        .scancode (sc_reg),
        .st       (st_reg),
        .st_next  (st_next),
        .res      (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !res.valid);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (advance && res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            sc_reg <= s_tdata;
        end
        if (advance && res.valid)
        begin
            out_data_reg <= {res.terminal_index, res.key_code, res.action};
        end
    end

endmodule

// ===== rtl/sckt_checker.sv =====
// Port-level checks for the scancode translator, bound to the top level.
// Depends on sckt_pkg and scancode_set1_key_translator_core_assert.svh.
`include "scancode_set1_key_translator_core_assert.svh"

module sckt_checker #(
    parameter int TERMINAL_COUNT = sckt_pkg::TERMINAL_COUNT_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata    // [3:0] action, [11:4] key_code, [13:12] terminal_index
);
    import sckt_pkg::*;

    logic [1:0] term_max;
    assign term_max = 2'(TERMINAL_COUNT - 1);

    `SCKT_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result changed while stalled")
    `SCKT_ASSERT_NOW(a_action_range, m_tvalid, m_tdata[3:0] <= ACT_MAXIMIZE,
        "action out of range")
    `SCKT_ASSERT_NOW(a_key_only, m_tvalid && m_tdata[3:0] != ACT_KEY, m_tdata[11:4] == 8'h00,
        "key code set on a non-key action")
    `SCKT_ASSERT_NOW(a_term_zero, m_tvalid && m_tdata[3:0] != ACT_TERMINAL,
        m_tdata[13:12] == 2'b00, "terminal index set on a non-terminal action")
    `SCKT_ASSERT_NOW(a_term_range, m_tvalid && m_tdata[3:0] == ACT_TERMINAL,
        m_tdata[13:12] <= term_max, "terminal index out of range")

endmodule

bind scancode_set1_key_translator_core sckt_checker #(
    .TERMINAL_COUNT(TERMINAL_COUNT)
) u_sckt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/scancode_set1_key_translator_core_checker.sv =====
// Checker for the set-1 scancode translator: watches both stream channels, predicts each result.
// Depends on sckt_pkg for scancode and action constants.
module scancode_set1_key_translator_core_checker #(
    parameter int TERMINAL_COUNT = sckt_pkg::TERMINAL_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          mismatches,
    output int          awaited,
    output int          results_checked,
    output logic [9:0]  actions_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import sckt_pkg::*;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] key_code;
        logic [1:0] terminal_index;
    } key_event_t;

    localparam logic [7:0] PLAIN_KEYS [64] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] SHIFTED_KEYS [64] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    logic ext_pending;
    logic shift_down;
    logic alt_down;
    logic ctrl_down;
    logic caps_lock;

    key_event_t expected_keys [$];

    function automatic bit is_letter(input logic [7:0] ch);
        return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    endfunction

    // advances the keyboard state by one byte; returns 1 when the byte yields a result
    function automatic bit translate_scancode(input logic [7:0] sc, output key_event_t ev);
        logic       released;
        int         kc;
        logic [7:0] ch;
        ev       = '0;
        released = sc[7];
        kc       = int'(sc[6:0]);
        if (sc == SC_PREFIX) begin
            ext_pending = 1'b1;
            return 1'b0;
        end
        if (ext_pending) begin
            ext_pending = 1'b0;
            if (released)
                return 1'b0;
            if (sc == SC_WIN_L || sc == SC_WIN_R) begin
                ev.action = ACT_MENU;
                return 1'b1;
            end
            // navigation codes, shifted selection variants at 0x90
            case (sc)
                SC_UP:    ch = shift_down ? 8'h90 : 8'h80;
                SC_DOWN:  ch = shift_down ? 8'h91 : 8'h81;
                SC_LEFT:  ch = shift_down ? 8'h92 : 8'h82;
                SC_RIGHT: ch = shift_down ? 8'h93 : 8'h83;
                SC_DEL:   ch = 8'h84;
                SC_HOME:  ch = shift_down ? 8'h94 : 8'h85;
                SC_END:   ch = shift_down ? 8'h95 : 8'h86;
                default:  ch = 8'h00;
            endcase
            ev.key_code = ch;
            return ch != 8'h00;
        end
        if (kc == int'(SC_ALT)) begin
            alt_down = !released;
            return 1'b0;
        end
        if (kc == int'(SC_CTRL)) begin
            ctrl_down = !released;
            return 1'b0;
        end
        if (kc == int'(SC_LSHIFT) || kc == int'(SC_RSHIFT)) begin
            shift_down = !released;
            return 1'b0;
        end
        if (kc == int'(SC_CAPS)) begin
            if (!released)
                caps_lock = !caps_lock;
            return 1'b0;
        end
        if (alt_down && !released) begin
            if (kc >= int'(SC_F1) && kc < int'(SC_F1) + TERMINAL_COUNT) begin
                ev.action         = ACT_TERMINAL;
                ev.terminal_index = 2'(kc - int'(SC_F1));
                return 1'b1;
            end
            if (kc >= int'(SC_F1) + TERMINAL_COUNT && kc <= int'(SC_F1) + TERMINAL_COUNT + 5) begin
                ev.action = ACT_FILES + 4'(kc - int'(SC_F1) - TERMINAL_COUNT);
                return 1'b1;
            end
        end
        if (!released && kc == int'(SC_F11)) begin
            ev.action = ACT_MAXIMIZE;
            return 1'b1;
        end
        if (!released && !alt_down && kc >= int'(SC_F1) && kc <= int'(SC_F10)) begin
            ev.key_code = FKEY_BASE + 8'(kc - int'(SC_F1));
            return 1'b1;
        end
        if (released || kc >= 64)
            return 1'b0;
        ch = shift_down ? SHIFTED_KEYS[kc] : PLAIN_KEYS[kc];
        if (caps_lock && is_letter(ch))
            ch = ch ^ 8'h20;
        if (ctrl_down && is_letter(ch))
            ch = (ch | 8'h20) - 8'h60;
        ev.key_code = ch;
        return ch != 8'h00;
    endfunction

    task automatic note_failure(input string what, input key_event_t want, input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected action %0d key %02h term %0d, got action %0d key %02h term %0d pad %0d",
                     $realtime, what, want.action, want.key_code, want.terminal_index,
                     got[3:0], got[11:4], got[13:12], got[15:14]);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        key_event_t ev;
        key_event_t want;
        if (!rst_n) begin
            ext_pending     = 1'b0;
            shift_down      = 1'b0;
            alt_down        = 1'b0;
            ctrl_down       = 1'b0;
            caps_lock       = 1'b0;
            mismatches      = 0;
            results_checked = 0;
            actions_seen    = '0;
            expected_keys.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_keys.size() == 0) begin
                    note_failure("result with no request pending", '0, m_tdata);
                end else begin
                    want = expected_keys.pop_front();
                    if (m_tdata[3:0] != want.action || m_tdata[11:4] != want.key_code ||
                        m_tdata[13:12] != want.terminal_index || m_tdata[15:14] != 2'b00)
                        note_failure("result mismatch", want, m_tdata);
                    results_checked++;
                    if (m_tdata[3:0] < 4'd10)
                        actions_seen[m_tdata[3:0]] = 1'b1;
                end
            end
            if (s_tvalid && s_tready) begin
                if (translate_scancode(s_tdata, ev))
                    expected_keys.push_back(ev);
            end
        end
        awaited = expected_keys.size();
    end

endmodule

// ===== test/scancode_set1_key_translator_core_tb.sv =====
// Testbench top for the set-1 scancode translator: clock, reset, request stimulus and verdict.
// Depends on sckt_pkg, the translator RTL and scancode_set1_key_translator_core_checker.
module scancode_set1_key_translator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sckt_pkg::*;

    localparam int TERMINAL_COUNT = TERMINAL_COUNT_DEF;
    localparam int HOLD_CYCLES    = 150;

    localparam logic [7:0] REL   = 8'h80;
    localparam logic [7:0] KEY_A = 8'h1E;
    localparam logic [7:0] KEY_Q = 8'h10;
    localparam logic [7:0] KEY_C = 8'h2E;
    localparam logic [7:0] KEY_1 = 8'h02;

    localparam logic [7:0] ALT_B   = {1'b0, SC_ALT};
    localparam logic [7:0] CTRL_B  = {1'b0, SC_CTRL};
    localparam logic [7:0] SHIFT_B = {1'b0, SC_LSHIFT};
    localparam logic [7:0] CAPS_B  = {1'b0, SC_CAPS};
    localparam logic [7:0] F1_B    = {1'b0, SC_F1};
    localparam logic [7:0] F10_B   = {1'b0, SC_F10};
    localparam logic [7:0] F11_B   = {1'b0, SC_F11};

    localparam logic [7:0] DIRECTED [29] = '{
        KEY_A, KEY_A | REL, F1_B, F10_B, F11_B, 8'hFF,
        SHIFT_B, KEY_1, SC_PREFIX, SC_UP, CAPS_B, KEY_Q, SHIFT_B | REL,
        CTRL_B, KEY_C, CTRL_B | REL,
        ALT_B, F1_B, F1_B + 8'd2, F1_B + 8'd8, F10_B, F11_B, ALT_B | REL,
        SC_PREFIX, SC_PREFIX, SC_WIN_L, SC_PREFIX, SC_UP | REL, 8'h00
    };
    localparam logic [7:0] EXT_KEYS [9] = '{
        SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_DEL, SC_HOME, SC_END, SC_WIN_L, SC_WIN_R
    };
    localparam logic [6:0] MOD_KEYS [5] = '{SC_ALT, SC_CTRL, SC_LSHIFT, SC_RSHIFT, SC_CAPS};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int          mismatches;
    int          awaited;
    int          results_checked;
    logic [9:0]  actions_seen;

    int          sent          = 0;
    bit          idle_on       = 1'b1;
    int          rx_cycle      = 0;
    int          rx_hold_until = 0;

    always #2 clk = ~clk;

    scancode_set1_key_translator_core #(
        .TERMINAL_COUNT(TERMINAL_COUNT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scancode_set1_key_translator_core_checker #(
        .TERMINAL_COUNT(TERMINAL_COUNT)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .awaited         (awaited),
        .results_checked (results_checked),
        .actions_seen    (actions_seen)
    );

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_cycle < rx_hold_until)
            m_tready <= 1'b0;
        else if (idle_on)
            m_tready <= ($urandom_range(99) >= 8);
        else
            m_tready <= 1'b1;
    end

    task automatic send_scancode(input logic [7:0] sc);
        while (idle_on && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sc;
        sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // the extra edge lets the checker count the last accepted request
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (awaited == 0);
        @(posedge clk);
    endtask

    // one keyboard gesture: typing, modifier change, extended key, function key or noise
    task automatic random_keystroke();
        logic [7:0] sc;
        logic       with_alt;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            sc = 8'($urandom_range(1, 57));
            send_scancode(sc);
            if ($urandom_range(1))
                send_scancode(sc | REL);
        end
        else if (pick < 55)
        begin
            sc = {1'b0, MOD_KEYS[$urandom_range(4)]};
            send_scancode($urandom_range(1) ? sc : (sc | REL));
        end
        else if (pick < 70)
        begin
            send_scancode(SC_PREFIX);
            if ($urandom_range(7) == 0)
                send_scancode(SC_PREFIX);
            sc = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : EXT_KEYS[$urandom_range(8)];
            send_scancode(sc);
            if (sc != SC_PREFIX && $urandom_range(1))
            begin
                send_scancode(SC_PREFIX);
                send_scancode(sc | REL);
            end
        end
        else if (pick < 85)
        begin
            with_alt = 1'($urandom_range(1));
            if (with_alt)
                send_scancode(ALT_B);
            sc = ($urandom_range(5) == 0) ? F11_B : 8'($urandom_range(F1_B, F10_B));
            send_scancode(sc);
            if ($urandom_range(1))
                send_scancode(sc | REL);
            if (with_alt)
                send_scancode(ALT_B | REL);
        end
        else
        begin
            send_scancode(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        #400us;
        $display("scancode_set1_key_translator_core test failed");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_scancode(DIRECTED[i]);
        drain_results();

        // receiver holds off while letters keep coming, so the block backs up
        rx_hold_until = rx_cycle + HOLD_CYCLES;
        repeat (24)
            send_scancode(8'($urandom_range(KEY_Q, KEY_Q + 8'd9)));

        while (sent < 400)
        begin
            idle_on = (sent < 250 || sent >= 360);
            random_keystroke();
            if (sent >= 200 && sent < 205)
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("%0d scancode requests sent (%0d directed), %0d results checked",
                 sent, $size(DIRECTED), results_checked);
        $display("%0d of 10 action kinds seen; receiver held off once for %0d cycles",
                 $countones(actions_seen), HOLD_CYCLES);
        if (mismatches == 0 && awaited == 0)
            $display("scancode_set1_key_translator_core test passed");
        else
            $display("scancode_set1_key_translator_core test failed");
        $finish;
    end

endmodule

// ===== scancode_set1_key_translator_core.f =====
+incdir+rtl
rtl/sckt_pkg.sv
rtl/sckt_decode.sv
rtl/scancode_set1_key_translator_core.sv
rtl/sckt_checker.sv
test/scancode_set1_key_translator_core_checker.sv
test/scancode_set1_key_translator_core_tb.sv
